/* rtl/rfo_pkg.sv */
// Shared types and constants for the ring FIFO with overwrite.
package rfo_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Request kinds.
    localparam logic MODE_PUT = 1'b0;
    localparam logic MODE_GET = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [WORD_WIDTH-1:0] put_word;
    } t_item;

    typedef struct packed {
        logic [1:0]            status;
        logic [WORD_WIDTH-1:0] read_word;
        logic                  dropped;
        logic [CNT_W-1:0]      fill_count;
        logic                  is_full;
        logic                  is_empty;
    } t_result;

    // Per-cell controls driven by the queue controller.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

/* rtl/rfo_cell.sv */
// One storage cell of the shifting queue.
module rfo_cell
    import rfo_pkg::*;
(
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [WORD_WIDTH-1:0] i_put_word,
    input  logic [WORD_WIDTH-1:0] i_next_word,
    output logic [WORD_WIDTH-1:0] o_word
);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;

    // Load wins over shift: the tail cell takes the new word while the rest move down.
    always_comb begin
        if (i_ctl.load) begin
            n_word = i_put_word;
        end else if (i_ctl.shift) begin
            n_word = i_next_word;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

/* rtl/ring_fifo_overwrite.sv */
// Top level of the ring FIFO with overwrite: controller and cell chain.
//
// Usage:
//   Request channel: drive i_item (mode, put_word) and raise i_start. A beat is
//   taken at every rising edge with i_start high and o_busy low. o_busy is never
//   raised, so one put or get is taken every cycle.
//   Result channel: exactly one result per request, on o_result with o_valid high
//   for one cycle, in the cycle after the request beat. The receiver cannot stall;
//   sample o_result whenever o_valid is high.
//   Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data.
//   Index 0 sets the capacity in use (0 acts as 1, above DEPTH acts as DEPTH)
//   and empties the queue; index 1 sets overwrite mode. Write only while idle.
// Structure:
//   The words sit in a row of cells with the oldest word at cell 0. A get reads
//   cell 0 and every cell takes its upper neighbor's word; a put loads the cell
//   at the fill count. A put into a full queue in overwrite mode shifts and loads
//   the top used cell in the same cycle, dropping the oldest word.
// Reset:
//   Synchronous, active low. The queue empties, capacity returns to DEPTH and
//   overwrite mode turns off. Cell contents are not cleared.
module ring_fifo_overwrite
    import rfo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_item                 i_item,
    output logic                  o_valid,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_capacity;
    logic                  r_overwrite;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_valid;
    t_result               r_result;
    t_result               n_result;

    logic [CNT_W-1:0]      cap_eff;
    logic                  accept;
    logic                  cfg_we;
    logic                  full;
    logic                  do_shift;
    logic                  do_load;
    logic [CNT_W-1:0]      load_idx;

    t_cell_ctl             cell_ctl [DEPTH];
    logic [WORD_WIDTH-1:0] cell_word [DEPTH];
    logic [WORD_WIDTH-1:0] next_word [DEPTH];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Clamp the programmed capacity into 1..DEPTH.
    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = CNT_W'(1);
        end else if (CNT_W'(r_capacity) > CNT_W'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(r_capacity);
        end
    end

    assign full = (r_count >= cap_eff);

    // Decide the request outcome and the chain controls.
    always_comb begin
        do_shift            = 1'b0;
        do_load             = 1'b0;
        load_idx            = r_count;
        n_count             = r_count;
        n_result.status     = ST_DONE;
        n_result.read_word  = '0;
        n_result.dropped    = 1'b0;
        if (i_item.mode == MODE_PUT) begin
            if (full && r_overwrite) begin
                // Drop the oldest word, store the new one at the top used cell.
                do_shift         = 1'b1;
                do_load          = 1'b1;
                load_idx         = r_count - CNT_W'(1);
                n_result.dropped = 1'b1;
            end else if (full) begin
                n_result.status = ST_FULL;
            end else begin
                do_load = 1'b1;
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_result.status = ST_EMPTY;
            end else begin
                do_shift           = 1'b1;
                n_result.read_word = cell_word[0];
                n_count            = r_count - CNT_W'(1);
            end
        end
        n_result.fill_count = n_count;
        n_result.is_full    = (n_count == cap_eff);
        n_result.is_empty   = (n_count == '0);
    end

    // Row of cells; each takes its upper neighbor's word on a shift.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_top
            assign next_word[g] = '0;
        end else begin : g_mid
            assign next_word[g] = cell_word[g + 1];
        end

        assign cell_ctl[g].shift = accept && do_shift;
        assign cell_ctl[g].load  = accept && do_load && (load_idx == CNT_W'(g));

        rfo_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[g]),
            .i_put_word  (i_item.put_word),
            .i_next_word (next_word[g]),
            .o_word      (cell_word[g])
        );
    end

    // Control state: capacity, overwrite mode, fill count, result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CFG_DATA_W'(DEPTH);
            r_overwrite <= 1'b0;
            r_count     <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
            if (cfg_we) begin
                case (i_cfg_index)
                    CFG_CAPACITY: begin
                        r_capacity <= i_cfg_data;
                        r_count    <= '0;
                    end
                    CFG_OVERWRITE: begin
                        r_overwrite <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result payload: hold until the next request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // The fill count never passes the capacity in use.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cap_eff)
        else $error("fill count above capacity");

    // Every request beat yields a result strobe in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("request without result");

    // No strobe without a request.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_valid)
        else $error("result without request");

    // A drop only happens on a put into a full queue, which stays full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.dropped) |->
            (o_result.status == ST_DONE && o_result.is_full))
        else $error("drop reported on a non-full queue");

    // An empty get reports an empty queue and a zero word.
    a_empty_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_EMPTY) |->
            (o_result.is_empty && o_result.read_word == '0))
        else $error("empty status with data");

endmodule

/* tb/tb_ring_fifo_overwrite.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the ring FIFO with overwrite: directed cases, then random traffic.
module tb_ring_fifo_overwrite;
    import rfo_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 30;
    localparam int N_PHASES     = 8;

    // Every input starts at a known value.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    t_item                 i_item      = '0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_busy;
    logic                  o_valid;
    logic                  o_cfg_ready;
    t_result               o_result;

    ring_fifo_overwrite dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Shadow copy of the queue: ring storage, pointers, count and registers.
    logic [WORD_WIDTH-1:0] slot_words [DEPTH];
    int                    head_ptr;
    int                    tail_ptr;
    int                    held_count;
    logic [CFG_DATA_W-1:0] capacity_reg;
    logic                  overwrite_reg;

    // Results still owed by the block, oldest first.
    t_result pending_results [$];
    t_result want_result;

    int n_items;
    int n_results;
    int n_cfg_writes;
    int n_dropped;
    int n_refused;
    int n_empty_gets;
    int n_errors;
    int n_cycles;

    // Capacity register as the queue uses it: 0 acts as 1, above DEPTH acts as DEPTH.
    function automatic int usable_capacity();
        if (capacity_reg == 0)
            return 1;
        if (int'(capacity_reg) > DEPTH)
            return DEPTH;
        return int'(capacity_reg);
    endfunction

    function automatic int step_ptr(int ptr, int cap);
        return (ptr + 1 >= cap) ? 0 : ptr + 1;
    endfunction

    function automatic void empty_queue();
        head_ptr   = 0;
        tail_ptr   = 0;
        held_count = 0;
    endfunction

    // Advance the shadow queue by one request and return the result it owes.
    function automatic t_result predict_request(t_item req);
        int      cap;
        t_result res;
        cap = usable_capacity();
        res = '0;
        res.status = ST_DONE;
        if (req.mode == MODE_PUT) begin
            // Full in overwrite mode: drop the oldest word to make room.
            if (held_count >= cap && overwrite_reg) begin
                head_ptr = step_ptr(head_ptr, cap);
                held_count--;
                res.dropped = 1'b1;
                n_dropped++;
            end
            if (held_count >= cap) begin
                // Refused put leaves the queue untouched.
                res.status = ST_FULL;
                n_refused++;
            end else begin
                slot_words[tail_ptr] = req.put_word;
                tail_ptr = step_ptr(tail_ptr, cap);
                held_count++;
            end
        end else if (held_count == 0) begin
            res.status = ST_EMPTY;
            n_empty_gets++;
        end else begin
            res.read_word = slot_words[head_ptr];
            head_ptr = step_ptr(head_ptr, cap);
            held_count--;
        end
        res.fill_count = CNT_W'(held_count);
        res.is_full    = (held_count == cap);
        res.is_empty   = (held_count == 0);
        return res;
    endfunction

    // Check every result beat against the oldest owed result. Outputs are
    // sampled at the edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_results++;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected result beat status=%0d word=%h fill=%0d",
                             $realtime, o_result.status, o_result.read_word,
                             o_result.fill_count);
            end else begin
                want_result = pending_results.pop_front();
                if (o_result.status     !== want_result.status     ||
                    o_result.read_word  !== want_result.read_word  ||
                    o_result.dropped    !== want_result.dropped    ||
                    o_result.fill_count !== want_result.fill_count ||
                    o_result.is_full    !== want_result.is_full    ||
                    o_result.is_empty   !== want_result.is_empty) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("%0t: result %0d mismatch", $realtime, n_results);
                        $display("  expected status=%0d word=%h dropped=%0d fill=%0d full=%0d empty=%0d",
                                 want_result.status, want_result.read_word,
                                 want_result.dropped, want_result.fill_count,
                                 want_result.is_full, want_result.is_empty);
                        $display("  actual   status=%0d word=%h dropped=%0d fill=%0d full=%0d empty=%0d",
                                 o_result.status, o_result.read_word, o_result.dropped,
                                 o_result.fill_count, o_result.is_full, o_result.is_empty);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if the block stops answering.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results owed",
                     n_cycles, pending_results.size());
            $display("ring_fifo_overwrite regression: fail");
            $finish;
        end
    end

    // Present one request and hold it until the block takes the beat. Start
    // stays high on return so back-to-back requests need no extra edge.
    task automatic send_request(input logic mode, input logic [WORD_WIDTH-1:0] word);
        t_item req;
        req.mode     = mode;
        req.put_word = word;
        i_item  <= req;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(predict_request(req));
        n_items++;
    endtask

    task automatic hold_off(input int n_idle);
        if (n_idle > 0) begin
            i_start <= 1'b0;
            repeat (n_idle) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain_results();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // One register beat; drop valid and let an edge pass before returning.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CAPACITY) begin
            // A capacity write always empties the queue.
            capacity_reg = data;
            empty_queue();
        end else begin
            overwrite_reg = data[0];
        end
        n_cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [CFG_DATA_W-1:0] cap, input logic ow);
        drain_results();
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_OVERWRITE, CFG_DATA_W'(ow));
    endtask

    // Requests in bursts of random length, with random gaps between bursts when with_gaps is set.
    task automatic run_traffic(input int n_req, input int put_pct, input bit with_gaps);
        int burst_left;
        burst_left = $urandom_range(16, 1);
        for (int k = 0; k < n_req; k++) begin
            send_request(($urandom_range(99) < put_pct) ? MODE_PUT : MODE_GET, $urandom);
            burst_left--;
            if (burst_left == 0) begin
                if (with_gaps)
                    hold_off($urandom_range(5, 1));
                burst_left = $urandom_range(16, 1);
            end
        end
    endtask

    // Straight after reset: empty get (carrying a word), extreme words, drain.
    task automatic test_after_reset();
        send_request(MODE_GET, {WORD_WIDTH{1'b1}});
        send_request(MODE_PUT, '0);
        send_request(MODE_PUT, {WORD_WIDTH{1'b1}});
        send_request(MODE_GET, $urandom);
        send_request(MODE_GET, '0);
    endtask

    // Overwrite off: the put past capacity is refused, then empty it out.
    task automatic test_refuse_when_full();
        set_mode(CFG_DATA_W'(3), 1'b0);
        repeat (4) send_request(MODE_PUT, $urandom);
        repeat (4) send_request(MODE_GET, $urandom);
    endtask

    // Overwrite on: puts past capacity drop the oldest word.
    task automatic test_drop_oldest();
        set_mode(CFG_DATA_W'(2), 1'b1);
        repeat (4) send_request(MODE_PUT, $urandom);
        repeat (2) send_request(MODE_GET, $urandom);
    endtask

    // Zero capacity acts as one; a capacity write discards held words.
    task automatic test_capacity_limits();
        set_mode(CFG_DATA_W'(0), 1'b0);
        send_request(MODE_PUT, $urandom);
        send_request(MODE_PUT, $urandom);
        send_request(MODE_GET, $urandom);
        send_request(MODE_PUT, $urandom);
        drain_results();
        write_reg(CFG_CAPACITY, CFG_DATA_W'(17));
        send_request(MODE_GET, $urandom);
    endtask

    // Random phases over a spread of settings: fill-heavy half, pause until
    // every result is back, then drain-heavy half so the ring wraps often.
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] caps [N_PHASES];
        logic                  ows  [N_PHASES];
        caps = '{CFG_DATA_W'(16), CFG_DATA_W'(16), CFG_DATA_W'(1), CFG_DATA_W'(2),
                 CFG_DATA_W'(31), CFG_DATA_W'(0),
                 5'($urandom_range(31, 0)), 5'($urandom_range(31, 0))};
        ows  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0))};
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_mode(caps[ph], ows[ph]);
            run_traffic(PHASE_ITEMS, 75, (ph % 3) != 2);
            drain_results();
            run_traffic(PHASE_ITEMS, 30, (ph % 3) != 2);
        end
    endtask

    initial begin
        capacity_reg  = CFG_DATA_W'(DEPTH);
        overwrite_reg = 1'b0;
        empty_queue();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_refuse_when_full();
        test_drop_oldest();
        test_capacity_limits();
        test_random_traffic();

        // Let the last result beat land, then account for anything still owed.
        drain_results();
        repeat (4) @(posedge i_clk);
        n_errors += pending_results.size();

        $display("covered %0d requests, %0d results, %0d register writes",
                 n_items, n_results, n_cfg_writes);
        $display("  %0d dropped oldest, %0d refused puts, %0d empty gets, %0d mismatches",
                 n_dropped, n_refused, n_empty_gets, n_errors);
        if (n_errors == 0)
            $display("ring_fifo_overwrite regression: pass");
        else
            $display("ring_fifo_overwrite regression: fail");
        $finish;
    end

endmodule
